// File: hdl/jsu_pkg.sv
// Shared types, codes and lookup functions for the JSON string unescape unit.
// No dependencies; imported by every module of the block.
package jsu_pkg;

   localparam int LENGTH_WIDTH_DEFAULT = 16;
   localparam int MAX_LEN_RESET        = 4096;
   localparam int QUEUE_DEPTH          = 4;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NO_QUOTE     = 3'd0,
      ERR_UNTERMINATED = 3'd1,
      ERR_BAD_ESCAPE   = 3'd2,
      ERR_BAD_UNICODE  = 3'd3,
      ERR_CONTROL      = 3'd4,
      ERR_TOO_LONG     = 3'd5
   } err_code_type;

   typedef enum logic [1:0] {
      TAIL_NONE = 2'd0,
      TAIL_DONE = 2'd1,
      TAIL_ERR  = 2'd2
   } tail_type;

   // One accepted text byte, classified: up to three decoded bytes and a tail.
   typedef struct packed {
      logic [1:0]   nbytes;
      logic [7:0]   byte0;
      logic [7:0]   byte1;
      logic [7:0]   byte2;
      tail_type     tail;
      err_code_type err;
   } item_type;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CTRL_LIMIT   = 8'h20;

   // {valid, digit value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // {valid, mapped byte} for single-letter escapes
   function automatic logic [8:0] escape_map(input logic [7:0] c);
      logic [8:0] r;
      unique case (c)
         8'h22:   r = {1'b1, 8'h22};
         8'h5C:   r = {1'b1, 8'h5C};
         8'h2F:   r = {1'b1, 8'h2F};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/jsu_front.sv
// Front end: scan state machine, one text byte per cycle while accept is high,
// classified into items. Depends on jsu_pkg.
module jsu_front #(
   parameter int LENGTH_WIDTH = jsu_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              text_byte,
   input  logic                    end_of_text,
   input  logic                    csr_write,
   input  logic [LENGTH_WIDTH-1:0] csr_max_string_length,
   output logic                    item_push,
   output jsu_pkg::item_type       item
);
   import jsu_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_TEXT,
      MODE_ESC,
      MODE_HEX
   } mode_type;

   mode_type                mode_ff, mode_in;
   logic [15:0]             acc_ff, acc_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic [LENGTH_WIDTH:0]   len_ff, len_in;
   logic [LENGTH_WIDTH-1:0] max_ff;

   logic [4:0]              hexv;
   logic [8:0]              escv;
   logic [15:0]             acc_next;
   logic [LENGTH_WIDTH:0]   len_sum;
   logic                    do_after;
   logic                    do_fail;
   err_code_type            fail_code;
   item_type                it;

   assign hexv     = hex_value(text_byte);
   assign escv     = escape_map(text_byte);
   assign acc_next = {acc_ff[11:0], hexv[3:0]};

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      do_after  = 1'b0;
      do_fail   = 1'b0;
      fail_code = ERR_NO_QUOTE;
      it        = '0;
      it.tail   = TAIL_NONE;
      it.err    = ERR_NO_QUOTE;

      unique case (mode_ff)
         MODE_IDLE: begin
            if (text_byte != CH_QUOTE) begin
               do_fail   = 1'b1;
               fail_code = ERR_NO_QUOTE;
            end else if (end_of_text) begin
               do_fail   = 1'b1;
               fail_code = ERR_UNTERMINATED;
            end else begin
               mode_in = MODE_TEXT;
               len_in  = '0;
            end
         end
         MODE_TEXT: begin
            if (text_byte == CH_QUOTE) begin
               it.tail = TAIL_DONE;
               mode_in = MODE_IDLE;
               acc_in  = '0;
               cnt_in  = '0;
               len_in  = '0;
            end else if (text_byte == CH_BACKSLASH) begin
               if (end_of_text) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_BAD_ESCAPE;
               end else begin
                  mode_in = MODE_ESC;
               end
            end else if (text_byte < CTRL_LIMIT) begin
               do_fail   = 1'b1;
               fail_code = ERR_CONTROL;
            end else begin
               it.nbytes = 2'd1;
               it.byte0  = text_byte;
               do_after  = 1'b1;
            end
         end
         MODE_ESC: begin
            if (text_byte == CH_U) begin
               if (end_of_text) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_BAD_UNICODE;
               end else begin
                  mode_in = MODE_HEX;
                  acc_in  = '0;
                  cnt_in  = '0;
               end
            end else if (!escv[8]) begin
               do_fail   = 1'b1;
               fail_code = ERR_BAD_ESCAPE;
            end else begin
               mode_in   = MODE_TEXT;
               it.nbytes = 2'd1;
               it.byte0  = escv[7:0];
               do_after  = 1'b1;
            end
         end
         MODE_HEX: begin
            if (!hexv[4]) begin
               do_fail   = 1'b1;
               fail_code = ERR_BAD_UNICODE;
            end else if (cnt_ff != 2'd3) begin
               acc_in = acc_next;
               cnt_in = cnt_ff + 2'd1;
               if (end_of_text) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_BAD_UNICODE;
               end
            end else begin
               // fourth digit: emit UTF-8 for the code point
               mode_in  = MODE_TEXT;
               acc_in   = '0;
               cnt_in   = '0;
               do_after = 1'b1;
               if (acc_next < 16'h0080) begin
                  it.nbytes = 2'd1;
                  it.byte0  = acc_next[7:0];
               end else if (acc_next < 16'h0800) begin
                  it.nbytes = 2'd2;
                  it.byte0  = 8'hC0 | {3'b000, acc_next[10:6]};
                  it.byte1  = 8'h80 | {2'b00, acc_next[5:0]};
               end else begin
                  it.nbytes = 2'd3;
                  it.byte0  = 8'hE0 | {4'h0, acc_next[15:12]};
                  it.byte1  = 8'h80 | {2'b00, acc_next[11:6]};
                  it.byte2  = 8'h80 | {2'b00, acc_next[5:0]};
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      len_sum = len_ff + {{(LENGTH_WIDTH-1){1'b0}}, it.nbytes};

      if (do_after) begin
         if (len_sum > {1'b0, max_ff}) begin
            do_fail   = 1'b1;
            fail_code = ERR_TOO_LONG;
         end else if (end_of_text) begin
            do_fail   = 1'b1;
            fail_code = ERR_UNTERMINATED;
         end else begin
            len_in = len_sum;
         end
      end

      if (do_fail) begin
         it.tail = TAIL_ERR;
         it.err  = fail_code;
         mode_in = MODE_IDLE;
         acc_in  = '0;
         cnt_in  = '0;
         len_in  = '0;
      end
   end

   assign item      = it;
   assign item_push = accept && (it.nbytes != 2'd0 || it.tail != TAIL_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         len_ff  <= '0;
         max_ff  <= LENGTH_WIDTH'(MAX_LEN_RESET);
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            acc_ff  <= acc_in;
            cnt_ff  <= cnt_in;
            len_ff  <= len_in;
         end
         if (csr_write) begin
            max_ff <= csr_max_string_length;
         end
      end
   end

endmodule

// File: hdl/jsu_queue.sv
// Small register queue of classified items between front and back end.
// Depends on jsu_pkg.
module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jsu_pkg::item_type push_item,
   input  logic              pop,
   output jsu_pkg::item_type pop_item,
   output logic              full,
   output logic              nonempty
);
   import jsu_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type      store_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [AW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign nonempty = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;
   assign pop_item = store_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/jsu_back.sv
// Back end: expands queued items into single results, one per cycle
// while popped, held in an output register. Depends on jsu_pkg.
module jsu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_nonempty,
   input  jsu_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [1:0]        rsp_result_kind,
   output logic [7:0]        rsp_decoded_byte,
   output logic [2:0]        rsp_error_code,
   output logic              rsp_run_last
);
   import jsu_pkg::*;

   item_type   cur_ff;
   logic       cur_valid_ff;
   logic [1:0] pos_ff;
   logic       out_valid_ff;
   kind_type   kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic [2:0] err_ff, err_in;
   logic       last_ff;

   logic [2:0] total;
   logic       cur_last;
   logic       out_free;
   logic       emit;

   assign total    = {1'b0, cur_ff.nbytes} + {2'b00, cur_ff.tail != TAIL_NONE};
   assign cur_last = ({1'b0, pos_ff} + 3'd1) == total;
   assign out_free = !out_valid_ff || rsp_pop;
   assign emit     = cur_valid_ff && out_free;
   assign q_pop    = q_nonempty && (!cur_valid_ff || (emit && cur_last));

   always_comb begin
      kind_in = KIND_BYTE;
      byte_in = '0;
      err_in  = '0;
      if ({1'b0, pos_ff} < {1'b0, cur_ff.nbytes}) begin
         unique case (pos_ff)
            2'd0:    byte_in = cur_ff.byte0;
            2'd1:    byte_in = cur_ff.byte1;
            default: byte_in = cur_ff.byte2;
         endcase
      end else if (cur_ff.tail == TAIL_DONE) begin
         kind_in = KIND_DONE;
      end else begin
         kind_in = KIND_ERR;
         err_in  = cur_ff.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            cur_valid_ff <= 1'b1;
            pos_ff       <= '0;
         end else if (emit) begin
            if (cur_last) begin
               cur_valid_ff <= 1'b0;
               pos_ff       <= '0;
            end else begin
               pos_ff <= pos_ff + 2'd1;
            end
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (q_pop) begin
         cur_ff <= q_item;
      end
      if (emit) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         err_ff  <= err_in;
         last_ff <= cur_last;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_decoded_byte = byte_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_run_last     = last_ff;

endmodule

// File: hdl/json_string_unescape_unit.sv
// JSON string unescape unit: one text byte accepted per cycle unless req_full,
// decoded bytes out one result per cycle while the output is popped. An item's
// first result passes the queue, current-item and output registers; the 4-entry
// queue between scanner and expander absorbs multi-byte UTF-8 runs. Synchronous
// active-high reset idles the scanner, empties queue and output, and sets the
// length limit to 4096. Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
module json_string_unescape_unit #(
   parameter int LENGTH_WIDTH = jsu_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [7:0]              req_text_byte,
   input  logic                    req_end_of_text,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [1:0]              rsp_result_kind,
   output logic [7:0]              rsp_decoded_byte,
   output logic [2:0]              rsp_error_code,
   output logic                    rsp_run_last,
   input  logic                    csr_write,
   input  logic [LENGTH_WIDTH-1:0] csr_max_string_length
);
   import jsu_pkg::*;

   item_type f_item;
   item_type q_item;
   logic     f_push;
   logic     q_full;
   logic     q_nonempty;
   logic     q_pop;
   logic     accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   jsu_front #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
      .clock                 (clock),
      .reset                 (reset),
      .accept                (accept),
      .text_byte             (req_text_byte),
      .end_of_text           (req_end_of_text),
      .csr_write             (csr_write),
      .csr_max_string_length (csr_max_string_length),
      .item_push             (f_push),
      .item                  (f_item)
   );

   jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .full      (q_full),
      .nonempty  (q_nonempty)
   );

   jsu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_nonempty       (q_nonempty),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_decoded_byte (rsp_decoded_byte),
      .rsp_error_code   (rsp_error_code),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

// File: hdl/jsu_checker.sv
// Port-level checks for json_string_unescape_unit, attached by bind.
// Depends on jsu_pkg.
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [1:0] rsp_result_kind,
   input logic [7:0] rsp_decoded_byte,
   input logic [2:0] rsp_error_code,
   input logic       rsp_run_last
);
   import jsu_pkg::*;

   // nothing survives reset on the result side
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // done and error always close the run of results for one byte
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind != KIND_BYTE) |-> rsp_run_last)
      else $error("done/error result not marked last");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind == KIND_ERR) |-> (rsp_error_code <= ERR_TOO_LONG))
      else $error("error code out of range");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind != KIND_BYTE) |-> (rsp_decoded_byte == 8'h00))
      else $error("byte field not zero on non-byte result");

   // a held result's kind stays put until its transfer
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_result_kind)))
      else $error("result changed while waiting");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_decoded_byte (rsp_decoded_byte),
   .rsp_error_code   (rsp_error_code),
   .rsp_run_last     (rsp_run_last)
);
